// ===== rtl/core/hcpf_pkg.sv =====
// Package: shared types, constants and byte-role codes for the HCP fragmenter.
`timescale 1ns / 1ps
`default_nettype none

package hcpf_pkg;

    localparam int DEF_MAX_PAYLOAD = 4095;   // largest message payload in bytes
    localparam int LEN_W           = 12;     // width of message_length
    localparam int GROUP_MAX       = 3;      // most beats one input item can cause

    localparam logic [7:0] CFG_RESET = 8'd29;  // max_link_payload after reset
    localparam logic [7:0] MIN_LINK  = 8'd3;   // smaller frame limits act as this

    // byte_role codes
    localparam logic [1:0] ROLE_PKT_HDR = 2'd0;
    localparam logic [1:0] ROLE_MSG_HDR = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] message_length;
        logic [6:0]       pipe_id;
        logic [1:0]       msg_type;
        logic [5:0]       instruction_code;
        logic             no_payload;
    } t_item;

    typedef struct packed {
        logic       message_last;
        logic       fragment_last;
        logic [1:0] byte_role;
        logic [7:0] out_byte;
    } t_beat;

    typedef struct packed {
        t_beat [GROUP_MAX-1:0] beats;   // beats[0] leaves first
        logic  [1:0]           count;
    } t_group;

endpackage

`default_nettype wire

// ===== rtl/core/hcpf_in_reg.sv =====
// Input register: holds one accepted item until the fragmenter core takes it.
`timescale 1ns / 1ps
`default_nettype none

module hcpf_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  hcpf_pkg::t_item     i_item,
    output logic                o_valid,
    output hcpf_pkg::t_item     o_item,
    input  wire                 i_take
);
    import hcpf_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hcpf_frag_core.sv =====
// Fragmenter core: message/fragment counters and the beat group for one item.
`timescale 1ns / 1ps
`default_nettype none

module hcpf_frag_core #(
    parameter int MAX_PAYLOAD = hcpf_pkg::DEF_MAX_PAYLOAD
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    input  wire  [7:0]          i_cfg_data,
    input  hcpf_pkg::t_item     i_item,
    input  wire                 i_load,
    output hcpf_pkg::t_group    o_group
);
    import hcpf_pkg::*;

    localparam int LEN_CAP = (MAX_PAYLOAD < (2**LEN_W - 1)) ? MAX_PAYLOAD : (2**LEN_W - 1);
    localparam int MBL_W   = $clog2(LEN_CAP + 2);
    localparam int CW      = (MBL_W > 8) ? MBL_W : 8;

    logic [7:0]       r_mlp;
    logic [MBL_W-1:0] r_mbl;
    logic [7:0]       r_fbl;
    logic             r_hp;

    logic [MBL_W-1:0] n_mbl;
    logic [7:0]       n_fbl;
    logic             n_hp;

    logic [MBL_W-1:0] len_s, mbl0, mbl_open, mbl_h, mbl_p, mbl_n;
    logic [7:0]       mlp_eff, cap, fbl_open, fbl_h, fbl_p, fbl_n;
    logic             start, open_last, h_ml, h_fl, p_ml, p_fl;
    t_beat            pkt_beat, mh_beat, pl_beat;

    always_comb begin
        len_s = (i_item.message_length > LEN_W'(LEN_CAP)) ? MBL_W'(LEN_CAP)
                                                          : MBL_W'(i_item.message_length);
        mlp_eff = (r_mlp < MIN_LINK) ? MIN_LINK : r_mlp;
        cap     = mlp_eff - 8'd1;

        start = r_hp || i_item.no_payload;
        mbl0  = (i_item.no_payload || len_s == '0) ? MBL_W'(1) : len_s + MBL_W'(1);

        // one fragment opener, shared by message start and mid-message refill
        mbl_open  = start ? mbl0 : r_mbl;
        open_last = CW'(mbl_open) <= CW'(cap);
        fbl_open  = open_last ? 8'(mbl_open) : cap;

        mbl_h = mbl0 - MBL_W'(1);
        fbl_h = fbl_open - 8'd1;
        h_ml  = (mbl_h == '0);
        h_fl  = (fbl_h == '0);

        if (start) begin
            mbl_p = mbl_h;
            fbl_p = fbl_h;
        end else begin
            mbl_p = r_mbl;
            fbl_p = (r_fbl == '0) ? fbl_open : r_fbl;
        end
        mbl_n = mbl_p - MBL_W'(1);
        fbl_n = fbl_p - 8'd1;
        p_ml  = (mbl_n == '0);
        p_fl  = (fbl_n == '0);

        pkt_beat = '{message_last: 1'b0, fragment_last: 1'b0, byte_role: ROLE_PKT_HDR,
                     out_byte: {open_last, i_item.pipe_id}};
        mh_beat  = '{message_last: h_ml, fragment_last: h_fl, byte_role: ROLE_MSG_HDR,
                     out_byte: {i_item.msg_type, i_item.instruction_code}};
        pl_beat  = '{message_last: p_ml, fragment_last: p_fl, byte_role: ROLE_PAYLOAD,
                     out_byte: i_item.data_byte};

        o_group = '0;
        n_mbl   = mbl_n;
        n_fbl   = fbl_n;
        n_hp    = p_ml;
        if (start) begin
            o_group.beats[0] = pkt_beat;
            o_group.beats[1] = mh_beat;
            if (h_ml) begin
                // empty message: header bytes only, data byte dropped
                o_group.count = 2'd2;
                n_mbl         = mbl_h;
                n_fbl         = fbl_h;
                n_hp          = 1'b1;
            end else begin
                o_group.beats[2] = pl_beat;
                o_group.count    = 2'd3;
            end
        end else if (r_fbl == '0) begin
            o_group.beats[0] = pkt_beat;
            o_group.beats[1] = pl_beat;
            o_group.count    = 2'd2;
        end else begin
            o_group.beats[0] = pl_beat;
            o_group.count    = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mlp <= CFG_RESET;
            r_mbl <= '0;
            r_fbl <= '0;
            r_hp  <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_mlp <= i_cfg_data;
            end
            if (i_load) begin
                r_mbl <= n_mbl;
                r_fbl <= n_fbl;
                r_hp  <= n_hp;
            end
        end
    end

`ifndef SYNTHESIS
    a_open_msg_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hp |-> r_mbl != '0)
        else $error("message open with no bytes left");
    a_single_beat_mid_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && o_group.count == 2'd1) |-> (!r_hp && r_fbl != '0))
        else $error("lone payload beat without an open fragment");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/hcpf_out_ser.sv =====
// Output serializer: result register for one beat group, sent one beat per cycle while i_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module hcpf_out_ser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  hcpf_pkg::t_group    i_group,
    output logic                o_load,
    output logic                o_valid,
    input  wire                 i_ready,
    output hcpf_pkg::t_beat     o_beat
);
    import hcpf_pkg::*;

    t_beat [GROUP_MAX-1:0] r_slot;
    logic  [1:0]           r_left;
    logic                  take;

    assign o_valid = (r_left != 2'd0);
    assign o_beat  = r_slot[0];
    assign take    = o_valid && i_ready;
    // refill when empty or while the last waiting beat leaves
    assign o_load  = i_valid && ((r_left == 2'd0) || (r_left == 2'd1 && i_ready));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (o_load) begin
            r_left <= i_group.count;
        end else if (take) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_slot <= i_group.beats;
        end else if (take) begin
            for (int k = 0; k < GROUP_MAX - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

`ifndef SYNTHESIS
    a_msg_last_ends_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_beat.message_last) |-> o_beat.fragment_last)
        else $error("message end not on a fragment end");
    a_pkt_hdr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_beat.byte_role == ROLE_PKT_HDR)
            |-> (!o_beat.fragment_last && !o_beat.message_last))
        else $error("packet header flagged as last");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_load)
        else $error("group loaded over waiting beats");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/hcp_message_fragmenter_unit.sv =====
// Top level: HCP message fragmenter, HCI message bytes in, link fragment bytes out.
// Path: an accepted beat is held in the input register, then its beat group in the result register.
// Throughput: 1 input beat per cycle mid-fragment while m_axis_tready is high; a beat
//   that opens a fragment gives 2 output beats and the first beat of a message 3 (packet
//   and message header, 2 if empty), set by the one-beat-per-cycle output register draining its beat group.
// Reset: synchronous active-low; clears valids, max_link_payload back to 29, next beat
//   starts a new message.
`timescale 1ns / 1ps
`default_nettype none

module hcp_message_fragmenter_unit #(
    parameter int MAX_PAYLOAD = hcpf_pkg::DEF_MAX_PAYLOAD
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // config: max_link_payload
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [7:0]   i_cfg_data,
    // message byte stream
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // low to high: data_byte[7:0], message_length[19:8], pipe_id[26:20],
    // msg_type[28:27], instruction_code[34:29], zero fill[39:35]
    input  wire  [39:0]  s_axis_tdata,
    // no_payload[0]
    input  wire  [0:0]   s_axis_tuser,
    // fragment byte stream
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]   m_axis_tdata,
    // byte_role[1:0], message_last[2]
    output logic [2:0]   m_axis_tuser,
    // fragment_last
    output logic         m_axis_tlast
);
    import hcpf_pkg::*;

    t_item  in_item, reg_item;
    t_group group;
    t_beat  beat;
    logic   reg_valid;
    logic   load;

    assign o_cfg_ready = 1'b1;   // the user writes config only while idle; the block does not enforce it

    // unpack the input beat
    assign in_item.data_byte        = s_axis_tdata[7:0];
    assign in_item.message_length   = s_axis_tdata[19:8];
    assign in_item.pipe_id          = s_axis_tdata[26:20];
    assign in_item.msg_type         = s_axis_tdata[28:27];
    assign in_item.instruction_code = s_axis_tdata[34:29];
    assign in_item.no_payload       = s_axis_tuser[0];

    hcpf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .o_item  (reg_item),
        .i_take  (load)
    );

    // counters advance only when the beat group moves to the output register
    hcpf_frag_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_item      (reg_item),
        .i_load      (load),
        .o_group     (group)
    );

    hcpf_out_ser u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (reg_valid),
        .i_group (group),
        .o_load  (load),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_beat  (beat)
    );

    assign m_axis_tdata = beat.out_byte;
    assign m_axis_tuser = {beat.message_last, beat.byte_role};
    assign m_axis_tlast = beat.fragment_last;

endmodule

`default_nettype wire
